// ===== src/wisp_pkg.sv =====
// wisp_pkg: shared types, constants and helpers for the weighted index sampler
// holds the command and result beat structs, opcode/status codes and the fsm state type
// no dependencies
package wisp_pkg;

	// table geometry
	localparam int TABLES = 3;
	localparam int ENTRIES = 64;
	localparam int TIDX_W = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int DEPTH = TABLES * ENTRIES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int TOT_W = 32;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_DRAW   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP
	} state_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [1:0]  table_select;
		logic [15:0] weight;
		logic [31:0] draw_value;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  chosen_index;
		logic [31:0] table_total;
		status_t     status;
	} result_t;

	// flat memory address of an entry within a table
	function automatic logic [ADDR_W-1:0] make_addr(
		input logic [TIDX_W-1:0] tbl,
		input logic [IDX_W-1:0]  idx
	);
		make_addr = ADDR_W'(tbl) * ADDR_W'(ENTRIES) + ADDR_W'(idx);
	endfunction

endpackage

// ===== src/wisp_ram.sv =====
// wisp_ram: generic single write port, single read port ram with registered read
// no package dependency; width and depth come from parameters
module wisp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/weighted_index_sampler_unit.sv =====
// weighted_index_sampler_unit: top level of the weighted index sampler
// depends on wisp_pkg for beat types and codes, and on wisp_ram for the running totals store
//
// Keeps three tables of up to 64 running weight totals. A command beat is taken when start is
// high and busy is low; exactly one result beat follows, shown on result for a single cycle
// with done high, and it cannot be held off, so it must be captured when done is seen. Clear,
// append, no-op, out-of-range table selects and flagged draws return their result in the
// cycle after the command. A draw that needs a search bisects the table's running totals
// through the single read port of the totals ram: each bisection step is a ram read followed
// by a compare, and busy is high throughout the search.
// No clearing pass is needed after reset; the block accepts commands straight away.
module weighted_index_sampler_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  wisp_pkg::cmd_t    cmd,
	output logic             done,
	output wisp_pkg::result_t result
);
	import wisp_pkg::*;

	// per table state
	logic [CNT_W-1:0] cnt_q [TABLES];
	logic [TOT_W-1:0] tot_q [TABLES];

	// search state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  lo_q, hi_q;
	logic [TIDX_W-1:0] tbl_q;
	logic [TOT_W-1:0]  val_q;
	logic [TOT_W-1:0]  stot_q;

	logic              done_q;
	result_t           result_q;

	// command decode
	logic              accept;
	logic              tsel_ok;
	logic [TIDX_W-1:0] tidx;
	logic [CNT_W-1:0]  cur_cnt;
	logic [TOT_W-1:0]  cur_tot;
	logic              go_search;
	logic              do_write;
	result_t           imm_res;

	// search datapath
	logic [CNT_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic              more;
	logic              ram_re;
	logic              step;
	logic              finish;
	logic [TOT_W-1:0]  rdata;

	assign accept  = start && !busy;
	assign tsel_ok = int'(cmd.table_select) < TABLES;
	assign tidx    = cmd.table_select[TIDX_W-1:0];
	assign cur_cnt = tsel_ok ? cnt_q[tidx] : '0;
	assign cur_tot = tsel_ok ? tot_q[tidx] : '0;

	// immediate result and decision to search
	always_comb begin
		imm_res   = '{chosen_index: '0, table_total: '0, status: STAT_OK};
		go_search = 1'b0;
		do_write  = 1'b0;
		if (!tsel_ok) begin
			imm_res.status = STAT_EMPTY;
		end else begin
			case (cmd.opcode)
				OP_CLEAR: begin
					imm_res.table_total = '0;
				end
				OP_APPEND: begin
					imm_res.table_total = cur_tot;
					if (int'(cur_cnt) >= ENTRIES) begin
						imm_res.status = STAT_FULL;
					end else begin
						imm_res.table_total  = cur_tot + TOT_W'(cmd.weight);
						imm_res.chosen_index = 6'(cur_cnt);
						do_write             = 1'b1;
					end
				end
				OP_DRAW: begin
					imm_res.table_total = cur_tot;
					if (cur_cnt == '0 || cur_tot == '0) begin
						imm_res.status = STAT_EMPTY;
					end else if (cmd.draw_value >= cur_tot) begin
						imm_res.status = STAT_RANGE;
					end else begin
						go_search = 1'b1;
					end
				end
				default: begin
					imm_res.table_total = cur_tot;
				end
			endcase
		end
	end

	// bisection midpoint
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign more    = lo_q < hi_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && go_search) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = more ? S_CMP : S_IDLE;
			end
			S_CMP: begin
				state_d = S_READ;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		busy   = 1'b1;
		ram_re = 1'b0;
		step   = 1'b0;
		finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
			end
			S_READ: begin
				ram_re = more;
				finish = !more;
			end
			S_CMP: begin
				step = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// running totals store
	wisp_ram #(
		.WIDTH (TOT_W),
		.DEPTH (DEPTH)
	) u_totals (
		.clk   (clk),
		.we    (accept && do_write),
		.waddr (make_addr(tidx, IDX_W'(cur_cnt))),
		.wdata (imm_res.table_total),
		.re    (ram_re),
		.raddr (make_addr(tbl_q, mid)),
		.rdata (rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per table counts and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLES; i++) begin
				cnt_q[i] <= '0;
				tot_q[i] <= '0;
			end
		end else if (accept && tsel_ok) begin
			if (cmd.opcode == OP_CLEAR) begin
				cnt_q[tidx] <= '0;
				tot_q[tidx] <= '0;
			end else if (do_write) begin
				cnt_q[tidx] <= cur_cnt + CNT_W'(1);
				tot_q[tidx] <= imm_res.table_total;
			end
		end
	end

	// search registers
	always_ff @(posedge clk) begin
		if (accept && go_search) begin
			lo_q   <= '0;
			hi_q   <= cur_cnt;
			tbl_q  <= tidx;
			val_q  <= cmd.draw_value;
			stot_q <= cur_tot;
		end else if (step) begin
			if (val_q < rdata) begin
				hi_q <= CNT_W'(mid);
			end else begin
				lo_q <= CNT_W'(mid) + CNT_W'(1);
			end
		end
	end

	// result beat strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !go_search) || finish;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= '{chosen_index: 6'(lo_q), table_total: stot_q, status: STAT_OK};
		end else if (accept) begin
			result_q <= imm_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	// a compare step always follows a ram read
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_READ)
		else $error("compare step without a preceding read");

	// bisection bounds never cross
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> lo_q <= hi_q)
		else $error("bisection bounds crossed");

	// a result beat is only shown once the search is over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result beat while search in flight");

	// a searched draw never lands past the upper search bound or on an index equal to ENTRIES
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> lo_q < hi_q + CNT_W'(1) && lo_q != CNT_W'(ENTRIES))
		else $error("draw index out of range");
`endif

endmodule

// ===== tb/weighted_index_sampler_unit_test.sv =====
// weighted_index_sampler_unit_test: self-checking bench for the weighted index sampler
// drives command beats from a queue, predicts each result beat and compares on done
// depends on wisp_pkg and weighted_index_sampler_unit
module weighted_index_sampler_unit_test;
	import wisp_pkg::*;

	typedef struct {
		cmd_t c;
		bit   hold;
	} queued_cmd_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	// stimulus and prediction stores
	queued_cmd_t command_queue[$];
	result_t     expected_results[$];
	result_t     want;

	// predicted table contents
	logic [31:0] run_total [TABLES][ENTRIES];
	int unsigned fill_count [TABLES];

	// stimulus-side view of the tables, used only to aim draw values
	logic [31:0] gen_sum [TABLES][ENTRIES];
	int unsigned gen_cnt [TABLES];
	bit          hold_next = 1'b0;

	int unsigned gap_left = 0;
	int unsigned beats_sent = 0;
	int          error_count = 0;
	logic        launch;

	weighted_index_sampler_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predict the result of one command and update the table state
	function automatic result_t apply_command(input cmd_t c);
		result_t     r;
		int unsigned t;
		int unsigned n;
		logic [31:0] sum;
		r = '0;
		r.status = STAT_OK;
		t = c.table_select;
		if (t >= TABLES) begin
			r.status = STAT_EMPTY;
			return r;
		end
		n = fill_count[t];
		sum = (n == 0) ? 32'd0 : run_total[t][n-1];
		case (c.opcode)
			OP_CLEAR: begin
				fill_count[t] = 0;
			end
			OP_APPEND: begin
				r.table_total = sum;
				if (n >= ENTRIES) begin
					r.status = STAT_FULL;
				end else begin
					sum = sum + 32'(c.weight);
					run_total[t][n] = sum;
					fill_count[t] = n + 1;
					r.chosen_index = 6'(n);
					r.table_total = sum;
				end
			end
			OP_DRAW: begin
				r.table_total = sum;
				if (n == 0 || sum == 0) begin
					r.status = STAT_EMPTY;
				end else if (c.draw_value >= sum) begin
					r.status = STAT_RANGE;
				end else begin
					// scan downwards so the lowest entry above the value wins
					for (int i = n - 1; i >= 0; i--)
						if (c.draw_value < run_total[t][i])
							r.chosen_index = 6'(i);
				end
			end
			default: begin
				r.table_total = sum;
			end
		endcase
		return r;
	endfunction

	// add one command to the stimulus queue and track the table it builds
	task automatic queue_command(input opcode_t op, input int unsigned tsel,
			input logic [15:0] w, input logic [31:0] v);
		queued_cmd_t q;
		int unsigned n;
		q.c.opcode = op;
		q.c.table_select = 2'(tsel);
		q.c.weight = w;
		q.c.draw_value = v;
		q.hold = hold_next;
		hold_next = 1'b0;
		command_queue.push_back(q);
		if (tsel < TABLES) begin
			n = gen_cnt[tsel];
			if (op == OP_CLEAR) begin
				gen_cnt[tsel] = 0;
			end else if (op == OP_APPEND && n < ENTRIES) begin
				gen_sum[tsel][n] = ((n == 0) ? 32'd0 : gen_sum[tsel][n-1]) + 32'(w);
				gen_cnt[tsel] = n + 1;
			end
		end
	endtask

	// draw value aimed mostly inside the table, often on running-total boundaries
	function automatic logic [31:0] pick_draw(input int unsigned tsel);
		int unsigned n;
		int unsigned r;
		logic [31:0] sum;
		if (tsel >= TABLES || gen_cnt[tsel] == 0)
			return $urandom;
		n = gen_cnt[tsel];
		sum = gen_sum[tsel][n-1];
		r = $urandom_range(0, 99);
		if (sum == 0 || r >= 88)
			return $urandom;
		if (r < 60)
			return $urandom_range(0, sum - 1);
		if (r < 76)
			return gen_sum[tsel][$urandom_range(0, n - 1)];
		if (r < 82)
			return sum - 1;
		return sum;
	endfunction

	// command driver: one beat at a time, random gaps, optional drain before a held beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left = 0;
		end else begin
			launch = start;
			if (start && !busy) begin
				expected_results.push_back(apply_command(cmd));
				beats_sent++;
				launch = 1'b0;
				// every third stretch of 64 beats runs back to back
				if ((beats_sent / 64) % 3 == 1)
					gap_left = 0;
				else
					gap_left = $urandom_range(0, 10);
			end
			if (!launch) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (command_queue.size() != 0 &&
						!(command_queue[0].hold && expected_results.size() != 0)) begin
					cmd <= command_queue[0].c;
					void'(command_queue.pop_front());
					launch = 1'b1;
				end
			end
			start <= launch;
		end
	end

	// result monitor: compare each beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no prediction pending");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.chosen_index !== want.chosen_index) begin
					$error("chosen_index: expected %0d, got %0d",
						want.chosen_index, result.chosen_index);
					error_count++;
				end
				if (result.table_total !== want.table_total) begin
					$error("table_total: expected %0d, got %0d",
						want.table_total, result.table_total);
					error_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					error_count++;
				end
			end
		end
	end

	// stimulus build, reset and end of run
	initial begin
		int unsigned tsel;
		int unsigned k;
		int unsigned r;
		int unsigned next_drain;

		for (int t = 0; t < TABLES; t++) begin
			fill_count[t] = 0;
			gen_cnt[t] = 0;
		end

		// directed: empty and zero-total draws, extremes, boundaries, bad table select
		queue_command(OP_DRAW, 0, 16'h0000, 32'd0);
		queue_command(OP_NOP, 0, 16'hFFFF, 32'hFFFFFFFF);
		queue_command(OP_APPEND, 0, 16'h0000, 32'd0);
		queue_command(OP_DRAW, 0, 16'h0000, 32'd0);
		queue_command(OP_APPEND, 0, 16'hFFFF, 32'd0);
		queue_command(OP_APPEND, 0, 16'h0001, 32'd0);
		queue_command(OP_DRAW, 0, 16'h0000, 32'd0);
		queue_command(OP_DRAW, 0, 16'h0000, 32'd65535);
		queue_command(OP_DRAW, 0, 16'h0000, 32'd65534);
		queue_command(OP_DRAW, 0, 16'h0000, 32'd65536);
		queue_command(OP_DRAW, 0, 16'h0000, 32'hFFFFFFFF);
		queue_command(OP_NOP, 0, 16'h0000, 32'd0);
		queue_command(OP_CLEAR, 3, 16'hFFFF, 32'hFFFFFFFF);
		queue_command(OP_APPEND, 3, 16'hFFFF, 32'hFFFFFFFF);
		queue_command(OP_DRAW, 3, 16'hFFFF, 32'd0);
		queue_command(OP_NOP, 3, 16'hFFFF, 32'hFFFFFFFF);
		queue_command(OP_CLEAR, 0, 16'h0000, 32'd0);
		queue_command(OP_DRAW, 0, 16'h0000, 32'd0);
		queue_command(OP_APPEND, 2, 16'h8000, 32'd0);
		queue_command(OP_DRAW, 2, 16'h0000, 32'h00007FFF);
		queue_command(OP_NOP, 2, 16'h0000, 32'd0);
		hold_next = 1'b1;
		queue_command(OP_CLEAR, 2, 16'h0000, 32'd0);

		// fill one table past its end with the largest weight
		hold_next = 1'b1;
		for (int i = 0; i < ENTRIES + 2; i++)
			queue_command(OP_APPEND, 1, 16'hFFFF, $urandom);
		queue_command(OP_DRAW, 1, 16'h0000, 32'd0);
		queue_command(OP_DRAW, 1, 16'h0000, 32'(ENTRIES) * 32'd65535 - 32'd1);
		queue_command(OP_DRAW, 1, 16'h0000, 32'(ENTRIES) * 32'd65535);
		queue_command(OP_DRAW, 1, 16'h0000, 32'd65535 * 32'd32);
		queue_command(OP_CLEAR, 1, 16'($urandom), $urandom);

		// random: mostly build-then-draw sequences, the rest noise
		next_drain = command_queue.size() + 90;
		while (command_queue.size() < 550) begin
			if (command_queue.size() >= next_drain) begin
				hold_next = 1'b1;
				next_drain += 90;
			end
			r = $urandom_range(0, 99);
			if (r < 80) begin
				tsel = $urandom_range(0, TABLES - 1);
				if ($urandom_range(0, 3) == 0)
					queue_command(OP_CLEAR, tsel, 16'($urandom), $urandom);
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
				for (int i = 0; i < k; i++)
					queue_command(OP_APPEND, tsel,
						($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
						$urandom);
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++)
					queue_command(OP_DRAW, tsel, 16'($urandom), pick_draw(tsel));
			end else begin
				tsel = $urandom_range(0, 3);
				queue_command(opcode_t'($urandom_range(0, 3)), tsel, 16'($urandom),
					($urandom_range(0, 1) == 0) ? $urandom : pick_draw(tsel));
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (command_queue.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
